### rtl/oyz_pkg.sv
// ----------------------------------------------------------------------------
// oyz_pkg: shared types and constants
// micro-op table, cordic angle table, command and status structs for the
// odometry yaw-zero euler unit
// ----------------------------------------------------------------------------
package oyz_pkg;

   localparam int CORDIC_STEPS_DEF = 16;

   localparam int STEP_W    = 5;
   localparam int CNT_W     = 6;
   localparam int PC_W      = 5;
   localparam int ACC_W     = 36;
   localparam int CW        = 38;
   localparam int ZW        = 34;
   localparam int SQ_W      = 57;
   localparam int ISQ_ITERS = 29;

   localparam logic signed [15:0] Q_ONE      = 16'sd16384;
   localparam logic signed [15:0] PITCH_LOCK = 16'sd16374;
   localparam logic signed [CW-1:0] CORDIC_KINV = 38'sd652032874;

   // micro-op program ranges
   localparam logic [PC_W-1:0] ZQ_FIRST  = 5'd0;
   localparam logic [PC_W-1:0] ZQ_LAST   = 5'd7;
   localparam logic [PC_W-1:0] DCM_FIRST = 5'd8;
   localparam logic [PC_W-1:0] DCM_LAST  = 5'd25;

   // multiplier operand selects
   localparam logic [3:0] OP_RW = 4'd0;
   localparam logic [3:0] OP_RX = 4'd1;
   localparam logic [3:0] OP_RY = 4'd2;
   localparam logic [3:0] OP_RZ = 4'd3;
   localparam logic [3:0] OP_EA = 4'd4;
   localparam logic [3:0] OP_EB = 4'd5;
   localparam logic [3:0] OP_EC = 4'd6;
   localparam logic [3:0] OP_ED = 4'd7;
   localparam logic [3:0] OP_C  = 4'd8;
   localparam logic [3:0] OP_S  = 4'd9;

   // accumulator destinations
   localparam logic [3:0] DS_ZW  = 4'd0;
   localparam logic [3:0] DS_ZX  = 4'd1;
   localparam logic [3:0] DS_ZY  = 4'd2;
   localparam logic [3:0] DS_ZZ  = 4'd3;
   localparam logic [3:0] DS_D00 = 4'd4;
   localparam logic [3:0] DS_D02 = 4'd5;
   localparam logic [3:0] DS_D10 = 4'd6;
   localparam logic [3:0] DS_D12 = 4'd7;
   localparam logic [3:0] DS_D20 = 4'd8;
   localparam logic [3:0] DS_D21 = 4'd9;
   localparam logic [3:0] DS_D22 = 4'd10;

   // cordic operand sources and result destinations
   localparam logic [1:0] CD_PITCH = 2'd0;
   localparam logic [1:0] CD_ROLL  = 2'd1;
   localparam logic [1:0] CD_YAW   = 2'd2;
   localparam logic [1:0] CD_SC    = 2'd3;

   typedef struct packed {
      logic [3:0] a_sel;
      logic [3:0] b_sel;
      logic       neg;
      logic       first;
      logic       last;
      logic [3:0] dest;
   } uop_type;

   typedef struct packed {
      logic              load;
      logic              mac;
      logic [PC_W-1:0]   pc;
      logic              sq1;
      logic              sq2;
      logic              isq;
      logic              cd_load;
      logic [1:0]        cd_src;
      logic              cd_iter;
      logic [STEP_W-1:0] cd_step;
      logic              cd_store;
      logic              out_load;
   } cmd_type;

   typedef struct packed {
      logic cap_now;
   } sts_type;

   function automatic uop_type mk(input logic [3:0] a, input logic [3:0] b,
                                  input logic n, input logic f, input logic l,
                                  input logic [3:0] d);
      uop_type u;
      u.a_sel = a;
      u.b_sel = b;
      u.neg   = n;
      u.first = f;
      u.last  = l;
      u.dest  = d;
      return u;
   endfunction

   // zq = q * conj(cos, 0, 0, sin) then the direction cosine terms
   function automatic uop_type uop(input logic [PC_W-1:0] pc);
      uop_type u;
      u = '0;
      unique case (pc)
         5'd0:  u = mk(OP_RW, OP_C,  1'b0, 1'b1, 1'b0, DS_ZW);
         5'd1:  u = mk(OP_RZ, OP_S,  1'b0, 1'b0, 1'b1, DS_ZW);
         5'd2:  u = mk(OP_RX, OP_C,  1'b0, 1'b1, 1'b0, DS_ZX);
         5'd3:  u = mk(OP_RY, OP_S,  1'b1, 1'b0, 1'b1, DS_ZX);
         5'd4:  u = mk(OP_RX, OP_S,  1'b0, 1'b1, 1'b0, DS_ZY);
         5'd5:  u = mk(OP_RY, OP_C,  1'b0, 1'b0, 1'b1, DS_ZY);
         5'd6:  u = mk(OP_RZ, OP_C,  1'b0, 1'b1, 1'b0, DS_ZZ);
         5'd7:  u = mk(OP_RW, OP_S,  1'b1, 1'b0, 1'b1, DS_ZZ);
         5'd8:  u = mk(OP_EA, OP_EA, 1'b0, 1'b1, 1'b0, DS_D00);
         5'd9:  u = mk(OP_EB, OP_EB, 1'b0, 1'b0, 1'b0, DS_D00);
         5'd10: u = mk(OP_EC, OP_EC, 1'b1, 1'b0, 1'b0, DS_D00);
         5'd11: u = mk(OP_ED, OP_ED, 1'b1, 1'b0, 1'b1, DS_D00);
         5'd12: u = mk(OP_EA, OP_EC, 1'b0, 1'b1, 1'b0, DS_D02);
         5'd13: u = mk(OP_EB, OP_ED, 1'b0, 1'b0, 1'b1, DS_D02);
         5'd14: u = mk(OP_EB, OP_EC, 1'b0, 1'b1, 1'b0, DS_D10);
         5'd15: u = mk(OP_EA, OP_ED, 1'b0, 1'b0, 1'b1, DS_D10);
         5'd16: u = mk(OP_EC, OP_ED, 1'b0, 1'b1, 1'b0, DS_D12);
         5'd17: u = mk(OP_EA, OP_EB, 1'b1, 1'b0, 1'b1, DS_D12);
         5'd18: u = mk(OP_EB, OP_ED, 1'b0, 1'b1, 1'b0, DS_D20);
         5'd19: u = mk(OP_EA, OP_EC, 1'b1, 1'b0, 1'b1, DS_D20);
         5'd20: u = mk(OP_EA, OP_EB, 1'b0, 1'b1, 1'b0, DS_D21);
         5'd21: u = mk(OP_EC, OP_ED, 1'b0, 1'b0, 1'b1, DS_D21);
         5'd22: u = mk(OP_EA, OP_EA, 1'b0, 1'b1, 1'b0, DS_D22);
         5'd23: u = mk(OP_EB, OP_EB, 1'b1, 1'b0, 1'b0, DS_D22);
         5'd24: u = mk(OP_EC, OP_EC, 1'b1, 1'b0, 1'b0, DS_D22);
         5'd25: u = mk(OP_ED, OP_ED, 1'b0, 1'b0, 1'b1, DS_D22);
         default: u = '0;
      endcase
      return u;
   endfunction

   // atan(2^-i) as a 32-bit binary angle
   function automatic logic [31:0] atan_entry(input logic [STEP_W-1:0] i);
      logic [31:0] a;
      a = '0;
      unique case (i)
         5'd0:  a = 32'h20000000;
         5'd1:  a = 32'h12E4051E;
         5'd2:  a = 32'h09FB385B;
         5'd3:  a = 32'h051111D4;
         5'd4:  a = 32'h028B0D43;
         5'd5:  a = 32'h0145D7E1;
         5'd6:  a = 32'h00A2F61E;
         5'd7:  a = 32'h00517C55;
         5'd8:  a = 32'h0028BE53;
         5'd9:  a = 32'h00145F2F;
         5'd10: a = 32'h000A2F98;
         5'd11: a = 32'h000517CC;
         5'd12: a = 32'h00028BE6;
         5'd13: a = 32'h000145F3;
         5'd14: a = 32'h0000A2FA;
         5'd15: a = 32'h0000517D;
         5'd16: a = 32'h000028BE;
         5'd17: a = 32'h0000145F;
         5'd18: a = 32'h00000A30;
         5'd19: a = 32'h00000518;
         5'd20: a = 32'h0000028C;
         5'd21: a = 32'h00000146;
         5'd22: a = 32'h000000A3;
         5'd23: a = 32'h00000051;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

### rtl/oyz_ctrl.sv
// ----------------------------------------------------------------------------
// oyz_ctrl: sequencer
// walks one request through the multiply, square root and cordic phases
// ----------------------------------------------------------------------------
module oyz_ctrl #(
   parameter int CORDIC_STEPS = oyz_pkg::CORDIC_STEPS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  oyz_pkg::sts_type sts,
   output oyz_pkg::cmd_type cmd
);
   import oyz_pkg::*;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_ZQ      = 4'd1;
   localparam logic [3:0] S_ZQ_END  = 4'd2;
   localparam logic [3:0] S_DCM     = 4'd3;
   localparam logic [3:0] S_DCM_END = 4'd4;
   localparam logic [3:0] S_SQ1     = 4'd5;
   localparam logic [3:0] S_SQ2     = 4'd6;
   localparam logic [3:0] S_ISQ     = 4'd7;
   localparam logic [3:0] S_PITCH   = 4'd8;
   localparam logic [3:0] S_ROLL    = 4'd9;
   localparam logic [3:0] S_YAW     = 4'd10;
   localparam logic [3:0] S_SC      = 4'd11;
   localparam logic [3:0] S_DONE    = 4'd12;

   localparam logic [CNT_W-1:0] CD_END = CNT_W'(CORDIC_STEPS + 1);

   logic [3:0]       state_ff, state_in, nxt;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [PC_W-1:0]  pc_ff, pc_in;
   logic             cap_ff, cap_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             cord;

   always_comb begin
      cmd          = '0;
      cmd.pc       = pc_ff;
      cmd.cd_step  = STEP_W'(cnt_ff - CNT_W'(1));
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pc_in        = pc_ff;
      cap_in       = cap_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      cord         = 1'b0;
      nxt          = S_IDLE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               cap_in   = sts.cap_now;
               cnt_in   = '0;
               pc_in    = sts.cap_now ? DCM_FIRST : ZQ_FIRST;
               state_in = sts.cap_now ? S_DCM : S_ZQ;
            end
         end
         S_ZQ: begin
            cmd.mac = 1'b1;
            pc_in   = pc_ff + PC_W'(1);
            if (pc_ff == ZQ_LAST) state_in = S_ZQ_END;
         end
         S_ZQ_END: state_in = cap_ff ? S_DONE : S_DCM;
         S_DCM: begin
            cmd.mac = 1'b1;
            pc_in   = pc_ff + PC_W'(1);
            if (pc_ff == DCM_LAST) state_in = S_DCM_END;
         end
         S_DCM_END: state_in = S_SQ1;
         S_SQ1: begin
            cmd.sq1  = 1'b1;
            state_in = S_SQ2;
         end
         S_SQ2: begin
            cmd.sq2  = 1'b1;
            cnt_in   = '0;
            state_in = S_ISQ;
         end
         S_ISQ: begin
            cmd.isq = 1'b1;
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(ISQ_ITERS - 1)) begin
               cnt_in   = '0;
               state_in = S_PITCH;
            end
         end
         S_PITCH: begin
            cord       = 1'b1;
            cmd.cd_src = CD_PITCH;
            nxt        = S_ROLL;
         end
         S_ROLL: begin
            cord       = 1'b1;
            cmd.cd_src = CD_ROLL;
            nxt        = S_YAW;
         end
         S_YAW: begin
            cord       = 1'b1;
            cmd.cd_src = CD_YAW;
            nxt        = cap_ff ? S_SC : S_DONE;
         end
         S_SC: begin
            cord       = 1'b1;
            cmd.cd_src = CD_SC;
            nxt        = S_ZQ;
            pc_in      = ZQ_FIRST;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // load, iterate, store for one cordic run
      if (cord) begin
         if (cnt_ff == '0) begin
            cmd.cd_load = 1'b1;
            cnt_in      = cnt_ff + CNT_W'(1);
         end else if (cnt_ff == CD_END) begin
            cmd.cd_store = 1'b1;
            cnt_in       = '0;
            state_in     = nxt;
         end else begin
            cmd.cd_iter = 1'b1;
            cnt_in      = cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         pc_ff        <= '0;
         cap_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pc_ff        <= pc_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

`ifndef SYNTH
   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff != S_IDLE))
      else $error("sequencer stayed idle after a request");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before it was taken");
   a_isq_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ISQ) |-> (cnt_ff < CNT_W'(ISQ_ITERS)))
      else $error("square root step count overran");
`endif

endmodule

### rtl/oyz_dp.sv
// ----------------------------------------------------------------------------
// oyz_dp: datapath
// origin and yaw state, shared multiplier, square root and cordic unit
// ----------------------------------------------------------------------------
module oyz_dp (
   input  logic             clock,
   input  logic             reset,
   input  logic [191:0]     req_tdata,
   input  logic             csr_we,
   input  logic [31:0]      csr_wdata,
   input  oyz_pkg::cmd_type cmd,
   output oyz_pkg::sts_type sts,
   output logic [207:0]     rsp_tdata,
   output logic             rsp_tuser
);
   import oyz_pkg::*;

   function automatic logic signed [15:0] sat_q(input logic signed [CW-1:0] t);
      logic signed [15:0] r;
      if (t > CW'(Q_ONE)) r = Q_ONE;
      else if (t < -CW'(Q_ONE)) r = -Q_ONE;
      else r = t[15:0];
      return r;
   endfunction

   function automatic logic [31:0] sat32(input logic signed [32:0] v);
      logic [31:0] r;
      if (v[32] != v[31]) r = v[32] ? 32'h80000000 : 32'h7FFFFFFF;
      else r = v[31:0];
      return r;
   endfunction

   // persistent state
   logic [31:0]        start_ff;
   logic               latched_ff;
   logic signed [31:0] org_x_ff, org_y_ff, org_z_ff;
   logic signed [15:0] hc_ff, hs_ff;

   // item
   logic [31:0]        req_time;
   logic signed [31:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic signed [15:0] rq_w_ff, rq_x_ff, rq_y_ff, rq_z_ff;
   logic signed [15:0] eq_a_ff, eq_b_ff, eq_c_ff, eq_d_ff;
   logic signed [15:0] zq_w_ff, zq_x_ff, zq_y_ff, zq_z_ff;
   logic               cap_ff;

   // multiply-accumulate
   uop_type                 u, u_ff;
   logic                    mac_v_ff;
   logic signed [15:0]      opa, opb;
   logic signed [31:0]      prod_ff;
   logic signed [ACC_W-1:0] acc_ff, sum, dbl;
   logic signed [CW-1:0]    qr;
   logic signed [15:0]      qv;
   logic signed [ACC_W-1:0] d00_ff, d02_ff, d10_ff, d12_ff, d20_ff, d21_ff, d22_ff;

   // square root
   logic signed [ACC_W-1:0] nd20;
   logic signed [29:0]      s_ff, s_in;
   logic signed [59:0]      ss;
   logic [SQ_W-1:0]         n_ff, res_ff, bit_ff;
   logic [SQ_W:0]           trial;

   // cordic
   logic signed [CW-1:0] cx_ff, cy_ff, vx, vy, shx, shy;
   logic signed [ZW-1:0] cz_ff, at, zr;
   logic                 rot_ff, zero_ff;
   logic signed [15:0]   ba;
   logic signed [15:0]   pitch_ff, roll_ff, yaw_ff;
   logic                 lock_up, lock_dn;

   // result
   logic [207:0] out_ff;
   logic         out_cap_ff;
   logic [31:0]  rel_x, rel_y, rel_z;

   assign req_time    = req_tdata[31:0];
   assign sts.cap_now = !latched_ff && (req_time < start_ff);

   // multiplier operands
   assign u = uop(cmd.pc);

   function automatic logic signed [15:0] opsel(
      input logic [3:0] sel,
      input logic signed [15:0] rw, input logic signed [15:0] rx,
      input logic signed [15:0] ry, input logic signed [15:0] rz,
      input logic signed [15:0] ea, input logic signed [15:0] eb,
      input logic signed [15:0] ec, input logic signed [15:0] ed,
      input logic signed [15:0] c, input logic signed [15:0] s);
      logic signed [15:0] r;
      unique case (sel)
         OP_RW:   r = rw;
         OP_RX:   r = rx;
         OP_RY:   r = ry;
         OP_RZ:   r = rz;
         OP_EA:   r = ea;
         OP_EB:   r = eb;
         OP_EC:   r = ec;
         OP_ED:   r = ed;
         OP_C:    r = c;
         OP_S:    r = s;
         default: r = '0;
      endcase
      return r;
   endfunction

   assign opa = opsel(u.a_sel, rq_w_ff, rq_x_ff, rq_y_ff, rq_z_ff,
                      eq_a_ff, eq_b_ff, eq_c_ff, eq_d_ff, hc_ff, hs_ff);
   assign opb = opsel(u.b_sel, rq_w_ff, rq_x_ff, rq_y_ff, rq_z_ff,
                      eq_a_ff, eq_b_ff, eq_c_ff, eq_d_ff, hc_ff, hs_ff);

   always_comb begin
      sum = (u_ff.first ? ACC_W'(0) : acc_ff) +
            (u_ff.neg ? -ACC_W'(prod_ff) : ACC_W'(prod_ff));
      dbl = sum <<< 1;
      qr  = (CW'(sum) + CW'(8192)) >>> 14;
      qv  = sat_q(qr);
   end

   // square root inputs
   always_comb begin
      nd20 = -d20_ff;
      if (nd20 > ACC_W'(1 << 28)) s_in = 30'sd268435456;
      else if (nd20 < -ACC_W'(1 << 28)) s_in = -30'sd268435456;
      else s_in = nd20[29:0];
      ss    = s_ff * s_ff;
      trial = {1'b0, res_ff} + {1'b0, bit_ff};
   end

   // cordic
   assign lock_up = (pitch_ff >= PITCH_LOCK);
   assign lock_dn = (pitch_ff <= -PITCH_LOCK);

   always_comb begin
      vx = '0;
      vy = '0;
      unique case (cmd.cd_src)
         CD_PITCH: begin
            vy = CW'(s_ff);
            vx = $signed({{(CW-29){1'b0}}, res_ff[28:0]});
         end
         CD_ROLL: begin
            vy = CW'(d21_ff);
            vx = CW'(d22_ff);
         end
         CD_YAW: begin
            if (lock_up) begin
               vy = CW'(d12_ff);
               vx = CW'(d02_ff);
            end else if (lock_dn) begin
               vy = -CW'(d12_ff);
               vx = -CW'(d02_ff);
            end else begin
               vy = CW'(d10_ff);
               vx = CW'(d00_ff);
            end
         end
         CD_SC: begin
            vy = '0;
            vx = CORDIC_KINV;
         end
         default: begin
            vy = '0;
            vx = '0;
         end
      endcase
      shx = cx_ff >>> cmd.cd_step;
      shy = cy_ff >>> cmd.cd_step;
      at  = $signed({{(ZW-32){1'b0}}, atan_entry(cmd.cd_step)});
      zr  = cz_ff + ZW'(32768);
      ba  = zero_ff ? 16'sd0 : zr[31:16];
   end

   // relative position
   assign rel_x = cap_ff ? 32'd0 : sat32(33'(pos_x_ff) - 33'(org_x_ff));
   assign rel_y = cap_ff ? 32'd0 : sat32(33'(pos_y_ff) - 33'(org_y_ff));
   assign rel_z = cap_ff ? 32'd0 : sat32(33'(pos_z_ff) - 33'(org_z_ff));

   // control and persistent state
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff   <= '0;
         latched_ff <= 1'b0;
         org_x_ff   <= '0;
         org_y_ff   <= '0;
         org_z_ff   <= '0;
         hc_ff      <= Q_ONE;
         hs_ff      <= '0;
         mac_v_ff   <= 1'b0;
      end else begin
         if (csr_we) start_ff <= csr_wdata;
         mac_v_ff <= cmd.mac;
         if (cmd.load) begin
            if (sts.cap_now) begin
               org_x_ff <= req_tdata[63:32];
               org_y_ff <= req_tdata[95:64];
               org_z_ff <= req_tdata[127:96];
            end else begin
               latched_ff <= 1'b1;
            end
         end
         if (cmd.cd_store && cmd.cd_src == CD_SC) begin
            hc_ff <= sat_q((cx_ff + CW'(32768)) >>> 16);
            hs_ff <= sat_q((cy_ff + CW'(32768)) >>> 16);
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pos_x_ff <= req_tdata[63:32];
         pos_y_ff <= req_tdata[95:64];
         pos_z_ff <= req_tdata[127:96];
         rq_w_ff  <= req_tdata[143:128];
         rq_x_ff  <= req_tdata[159:144];
         rq_y_ff  <= req_tdata[175:160];
         rq_z_ff  <= req_tdata[191:176];
         eq_a_ff  <= req_tdata[143:128];
         eq_b_ff  <= req_tdata[159:144];
         eq_c_ff  <= req_tdata[175:160];
         eq_d_ff  <= req_tdata[191:176];
         cap_ff   <= sts.cap_now;
      end

      prod_ff <= opa * opb;
      u_ff    <= u;
      if (mac_v_ff) begin
         acc_ff <= sum;
         if (u_ff.last) begin
            unique case (u_ff.dest)
               DS_ZW: begin zq_w_ff <= qv; eq_a_ff <= qv; end
               DS_ZX: begin zq_x_ff <= qv; eq_b_ff <= qv; end
               DS_ZY: begin zq_y_ff <= qv; eq_c_ff <= qv; end
               DS_ZZ: begin zq_z_ff <= qv; eq_d_ff <= qv; end
               DS_D00: d00_ff <= sum;
               DS_D02: d02_ff <= dbl;
               DS_D10: d10_ff <= dbl;
               DS_D12: d12_ff <= dbl;
               DS_D20: d20_ff <= dbl;
               DS_D21: d21_ff <= dbl;
               DS_D22: d22_ff <= sum;
               default: ;
            endcase
         end
      end

      if (cmd.sq1) s_ff <= s_in;
      if (cmd.sq2) begin
         n_ff   <= {1'b1, {(SQ_W-1){1'b0}}} - ss[SQ_W-1:0];
         res_ff <= '0;
         bit_ff <= {1'b1, {(SQ_W-1){1'b0}}};
      end
      if (cmd.isq) begin
         if ({1'b0, n_ff} >= trial) begin
            n_ff   <= n_ff - trial[SQ_W-1:0];
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end

      if (cmd.cd_load) begin
         rot_ff  <= (cmd.cd_src == CD_SC);
         zero_ff <= (cmd.cd_src != CD_SC) && (vx == '0) && (vy == '0);
         if (cmd.cd_src == CD_SC) begin
            cx_ff <= vx;
            cy_ff <= vy;
            cz_ff <= $signed({{(ZW-31){yaw_ff[15]}}, yaw_ff, 15'b0});
         end else if (vx < 0) begin
            if (vy >= 0) begin
               cx_ff <= vy;
               cy_ff <= -vx;
               cz_ff <= ZW'(32'sh40000000);
            end else begin
               cx_ff <= -vy;
               cy_ff <= vx;
               cz_ff <= -ZW'(32'sh40000000);
            end
         end else begin
            cx_ff <= vx;
            cy_ff <= vy;
            cz_ff <= '0;
         end
      end
      if (cmd.cd_iter) begin
         if (rot_ff ? (cz_ff >= 0) : (cy_ff < 0)) begin
            cx_ff <= cx_ff - shy;
            cy_ff <= cy_ff + shx;
            cz_ff <= rot_ff ? (cz_ff - at) : (cz_ff - at);
         end else begin
            cx_ff <= cx_ff + shy;
            cy_ff <= cy_ff - shx;
            cz_ff <= cz_ff + at;
         end
      end
      if (cmd.cd_store) begin
         unique case (cmd.cd_src)
            CD_PITCH: pitch_ff <= ba;
            CD_ROLL:  roll_ff  <= (lock_up || lock_dn) ? 16'sd0 : ba;
            CD_YAW:   yaw_ff   <= ba;
            default:  ;
         endcase
      end

      if (cmd.out_load) begin
         out_ff <= {(cap_ff ? 16'd0 : yaw_ff), pitch_ff, roll_ff,
                    zq_z_ff, zq_y_ff, zq_x_ff, zq_w_ff, rel_z, rel_y, rel_x};
         out_cap_ff <= cap_ff;
      end
   end

   assign rsp_tdata = out_ff;
   assign rsp_tuser = out_cap_ff;

endmodule

### rtl/odometry_yaw_zero_euler_unit.sv
// ----------------------------------------------------------------------------
// odometry_yaw_zero_euler_unit: origin capture, heading zero, 3-2-1 euler
// one 16x16 multiplier, a 29-step square root and one cordic work in series;
//   a capture request adds the half-yaw sin/cos run
// throughput: one request at a time, the next can be taken in the cycle after
//   the result is registered; a registered result may wait while work goes on
// reset: synchronous, clears the capture end time, latch and origin, yaw identity
// ----------------------------------------------------------------------------
module odometry_yaw_zero_euler_unit #(
   parameter int CORDIC_STEPS = oyz_pkg::CORDIC_STEPS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   // control_time, position_x, position_y, position_z, quat_w, quat_x,
   // quat_y, quat_z
   input  logic [191:0] req_tdata,
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // rel_x, rel_y, rel_z, zq_w, zq_x, zq_y, zq_z, roll_out, pitch_out, yaw_out
   output logic [207:0] rsp_tdata,
   // capturing
   output logic         rsp_tuser,
   // capture end time register
   input  logic         csr_we,
   input  logic [31:0]  csr_wdata
);
   import oyz_pkg::*;

   // command and status between sequencer and datapath
   cmd_type cmd;
   sts_type sts;

   // sequencer: phases and step counters
   oyz_ctrl #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // datapath: state, multiplier, square root, cordic, result register
   oyz_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

### sim/oyz_checker.sv
// ----------------------------------------------------------------------------
// oyz_checker: result predictor and scoreboard
// watches the request, result and register ports of the yaw-zero euler unit,
// computes the expected result of every accepted request in fixed point and
// compares it with the results in order
// ----------------------------------------------------------------------------
module oyz_checker #(
   parameter int STEPS = oyz_pkg::CORDIC_STEPS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [191:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [207:0] rsp_tdata,
   input  logic         rsp_tuser,
   input  logic         csr_we,
   input  logic [31:0]  csr_wdata,
   output int           fail_count,
   output int           pending
);

   // laid out as {rsp_tdata, rsp_tuser}, highest field first
   typedef struct packed {
      logic [15:0] yaw;
      logic [15:0] pitch;
      logic [15:0] roll;
      logic [15:0] zq_z;
      logic [15:0] zq_y;
      logic [15:0] zq_x;
      logic [15:0] zq_w;
      logic [31:0] rel_z;
      logic [31:0] rel_y;
      logic [31:0] rel_x;
      logic        cap;
   } pose_type;

   localparam longint ATAN_TAB [24] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
      64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};
   localparam int NSTEP = (STEPS > 24) ? 24 : STEPS;
   localparam longint QONE = 16384;
   localparam longint LOCK = 16374;

   pose_type    pose_q[$];
   logic [31:0] start_reg;
   logic        latched;
   longint      org_x, org_y, org_z, half_c, half_s;

   function automatic longint clampv(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // 32-bit binary angle to a wrapped 16-bit one, rounded half up
   function automatic longint angle16(longint acc);
      logic [15:0] r;
      r = 16'((acc + 32768) >>> 16);
      return longint'($signed(r));
   endfunction

   function automatic longint vec_angle(longint y_in, longint x_in);
      longint x, y, z, t;
      x = x_in;
      y = y_in;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = 64'sh40000000;
         end else begin
            x = -y; y = t; z = -64'sh40000000;
         end
      end
      for (int i = 0; i < NSTEP; i++) begin
         t = x;
         if (y >= 0) begin
            x += y >>> i; y -= t >>> i; z += ATAN_TAB[i];
         end else begin
            x -= y >>> i; y += t >>> i; z -= ATAN_TAB[i];
         end
      end
      return angle16(z);
   endfunction

   function automatic void rot_sincos(input longint ang, output longint c,
                                      output longint s);
      longint x, y, z, t;
      x = 652032874;
      y = 0;
      z = ang;
      for (int i = 0; i < NSTEP; i++) begin
         t = x;
         if (z >= 0) begin
            x -= y >>> i; y += t >>> i; z -= ATAN_TAB[i];
         end else begin
            x += y >>> i; y -= t >>> i; z += ATAN_TAB[i];
         end
      end
      c = clampv((x + 32768) >>> 16, -QONE, QONE);
      s = clampv((y + 32768) >>> 16, -QONE, QONE);
   endfunction

   function automatic longint root64(longint unsigned n_in);
      longint unsigned n, res, b;
      n = n_in;
      res = 0;
      b = 64'h1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b; res = (res >> 1) + b;
         end else res >>= 1;
         b >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic void euler_angles(input longint a, b, c, d,
                                        output longint roll, pitch, yaw);
      longint d00, d02, d10, d12, d20, d21, d22, s, co;
      d00 = a*a + b*b - c*c - d*d;
      d02 = 2 * (a*c + b*d);
      d10 = 2 * (b*c + a*d);
      d12 = 2 * (c*d - a*b);
      d20 = 2 * (b*d - a*c);
      d21 = 2 * (a*b + c*d);
      d22 = a*a - b*b - c*c + d*d;
      s = clampv(-d20, -(64'sd1 << 28), 64'sd1 << 28);
      co = root64((64'h1 << 56) - longint'(s * s));
      pitch = vec_angle(s, co);
      if (pitch >= LOCK) begin
         // gimbal lock nose up
         roll = 0; yaw = vec_angle(d12, d02);
      end else if (pitch <= -LOCK) begin
         roll = 0; yaw = vec_angle(-d12, -d02);
      end else begin
         roll = vec_angle(d21, d22); yaw = vec_angle(d10, d00);
      end
   endfunction

   function automatic longint round14(longint v);
      return clampv((v + 8192) >>> 14, -QONE, QONE);
   endfunction

   function automatic pose_type predict_pose(logic [191:0] d);
      pose_type r;
      longint   px, py, pz, qw, qx, qy, qz, roll, pitch, yaw, zw, zx, zy, zz;
      logic     cap;
      px = longint'($signed(d[63:32]));
      py = longint'($signed(d[95:64]));
      pz = longint'($signed(d[127:96]));
      qw = longint'($signed(d[143:128]));
      qx = longint'($signed(d[159:144]));
      qy = longint'($signed(d[175:160]));
      qz = longint'($signed(d[191:176]));
      cap = !latched && (d[31:0] < start_reg);
      if (cap) begin
         org_x = px; org_y = py; org_z = pz;
         euler_angles(qw, qx, qy, qz, roll, pitch, yaw);
         rot_sincos(yaw * 32768, half_c, half_s);
      end else latched = 1'b1;
      zw = round14(qw*half_c + qz*half_s);
      zx = round14(qx*half_c - qy*half_s);
      zy = round14(qx*half_s + qy*half_c);
      zz = round14(qz*half_c - qw*half_s);
      r = '0;
      if (cap) yaw = 0;
      else begin
         euler_angles(zw, zx, zy, zz, roll, pitch, yaw);
         r.rel_x = 32'(clampv(px - org_x, -(64'sd1 << 31), (64'sd1 << 31) - 1));
         r.rel_y = 32'(clampv(py - org_y, -(64'sd1 << 31), (64'sd1 << 31) - 1));
         r.rel_z = 32'(clampv(pz - org_z, -(64'sd1 << 31), (64'sd1 << 31) - 1));
      end
      r.zq_w = 16'(zw); r.zq_x = 16'(zx); r.zq_y = 16'(zy); r.zq_z = 16'(zz);
      r.roll = 16'(roll); r.pitch = 16'(pitch); r.yaw = 16'(yaw);
      r.cap = cap;
      return r;
   endfunction

   assign pending = pose_q.size();

   always @(posedge clock) begin
      pose_type exp_p, got;
      if (reset) begin
         start_reg <= '0;
         latched = 1'b0;
         org_x = 0; org_y = 0; org_z = 0;
         half_c = QONE; half_s = 0;
         pose_q.delete();
         fail_count <= 0;
      end else begin
         if (csr_we) start_reg <= csr_wdata;
         if (req_tvalid && req_tready) pose_q.push_back(predict_pose(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata, rsp_tuser};
            if (pose_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected result %p", got);
               fail_count <= fail_count + 1;
            end else begin
               exp_p = pose_q.pop_front();
               if (exp_p.rel_x !== got.rel_x || exp_p.rel_y !== got.rel_y ||
                   exp_p.rel_z !== got.rel_z || exp_p.zq_w !== got.zq_w ||
                   exp_p.zq_x !== got.zq_x || exp_p.zq_y !== got.zq_y ||
                   exp_p.zq_z !== got.zq_z || exp_p.roll !== got.roll ||
                   exp_p.pitch !== got.pitch || exp_p.yaw !== got.yaw ||
                   exp_p.cap !== got.cap) begin
                  if (fail_count < 10) begin
                     $display("mismatch expected %p", exp_p);
                     $display("         actual   %p", got);
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: regression for the odometry yaw-zero euler unit
// origin captures first, then latched requests over several capture end times,
// random idles on both channels and one long result hold-off;
// checking is done by oyz_checker beside the block
// ----------------------------------------------------------------------------
module tb_top;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [191:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [207:0] rsp_tdata;
   logic         rsp_tuser;
   logic         csr_we = 1'b0;
   logic [31:0]  csr_wdata = '0;
   int           fail_count;
   int           pending;
   bit           no_idle = 1'b0;   // stretch with no idling on either side
   bit           hold_req = 1'b0;  // asks the receiver for a long hold-off
   bit           hold_done = 1'b0;

   // 12 unit clock period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   odometry_yaw_zero_euler_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   oyz_checker chk (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending)
   );

   // result side: random ready, plus one long hold-off counted here
   initial begin
      int hold_cnt;
      forever begin
         @(posedge clock);
         if (hold_req && !hold_done) begin
            rsp_tready <= 1'b0;
            for (hold_cnt = 0; hold_cnt < 600; hold_cnt++) @(posedge clock);
            hold_done = 1'b1;
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= no_idle || ($urandom_range(99) >= 21);
         end
      end
   end

   // hold one request on the channel until it is taken
   task automatic send_request(input logic [31:0] t, input logic [31:0] px, py, pz,
                               input logic [15:0] qw, qx, qy, qz);
      if (!no_idle && $urandom_range(99) < 21) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {qz, qy, qx, qw, pz, py, px, t};
      do @(posedge clock); while (!req_tready);
   endtask

   // random quaternion: mostly in range, sometimes any 16 bits, sometimes near lock
   task automatic rand_quat(output logic [15:0] qw, qx, qy, qz);
      int sel;
      sel = $urandom_range(99);
      if (sel < 10) begin
         qw = 16'($urandom); qx = 16'($urandom); qy = 16'($urandom);
         qz = 16'($urandom);
      end else if (sel < 20) begin
         // pitch near plus or minus a right angle
         qw = 16'(11585 + $urandom_range(0, 20) - 10);
         qx = 16'($urandom_range(0, 40) - 20);
         qy = ($urandom_range(1)) ? 16'(11585 + $urandom_range(0, 20) - 10)
                                  : 16'(-11585 + $urandom_range(0, 20) - 10);
         qz = 16'($urandom_range(0, 40) - 20);
      end else begin
         qw = 16'($urandom_range(32768) - 16384);
         qx = 16'($urandom_range(32768) - 16384);
         qy = 16'($urandom_range(32768) - 16384);
         qz = 16'($urandom_range(32768) - 16384);
      end
   endtask

   task automatic rand_request(input logic [31:0] t);
      logic [15:0] qw, qx, qy, qz;
      logic [31:0] px, py, pz;
      rand_quat(qw, qx, qy, qz);
      if ($urandom_range(3) == 0) begin
         px = $urandom; py = $urandom; pz = $urandom;
      end else begin
         px = 32'($urandom_range(2000000) - 1000000);
         py = 32'($urandom_range(2000000) - 1000000);
         pz = 32'($urandom_range(2000000) - 1000000);
      end
      send_request(t, px, py, pz, qw, qx, qy, qz);
   endtask

   // register write with the block drained
   task automatic write_start(input logic [31:0] v);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      logic [31:0] phase_val [4];
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // origin captures: capture end time at its top so every time but the max captures
      write_start(32'hFFFF_FFFF);
      send_request(32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                   16'sd16384, 16'sd0, 16'sd0, 16'sd0);
      send_request(32'h1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                   16'sd11585, 16'sd0, 16'sd0, 16'sd11585);  // yaw right angle
      send_request(32'h10, 32'h1234_5678, 32'h0, 32'h0,
                   16'sd11585, 16'sd0, 16'sd11585, 16'sd0);   // nose straight up
      send_request(32'h100, 32'h0, 32'h0, 32'h0,
                   16'sd11585, 16'sd0, -16'sd11585, 16'sd0);  // nose straight down
      send_request(32'h1000, 32'h0, 32'h0, 32'h0,
                   16'sd0, 16'sd0, 16'sd0, 16'sd0);           // zero quaternion
      send_request(32'hFFFF_FFFE, 32'h0, 32'h0, 32'h0,
                   16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);   // out of range parts
      send_request(32'h2000, 32'h0001_0000, 32'hFFFF_0000, 32'h10,
                   16'sd0, 16'sd0, 16'sd0, -16'sd16384);      // yaw of pi
      send_request(32'h3000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F,
                   16'sd13000, 16'sd5000, -16'sd6000, 16'sd7000);
      // time equal to the capture end time latches for good
      send_request(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                   16'sd16384, 16'sd0, 16'sd0, 16'sd0);
      send_request(32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                   16'sd11585, 16'sd0, 16'sd11585, 16'sd0);
      send_request(32'h5, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000,
                   16'sd11585, 16'sd0, -16'sd11585, 16'sd0);
      send_request(32'h6, 32'h0, 32'h0, 32'h0,
                   -16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384);

      // latched phases over several capture end times
      phase_val[0] = 32'h0;
      phase_val[1] = 32'hFFFF_FFFF;
      phase_val[2] = $urandom;
      phase_val[3] = 32'h1;
      for (int ph = 0; ph < 4; ph++) begin
         write_start(phase_val[ph]);
         for (int n = 0; n < 310; n++) begin
            no_idle = (ph == 1 && n >= 100 && n < 200);
            if (ph == 2 && n == 50) hold_req = 1'b1;
            rand_request($urandom);
         end
         no_idle = 1'b0;
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("odometry_yaw_zero_euler_unit regression: pass");
      else
         $display("odometry_yaw_zero_euler_unit regression: fail");
      $finish;
   end

   // run limit
   initial begin
      #80000000;
      $display("odometry_yaw_zero_euler_unit regression: fail");
      $finish;
   end

endmodule

### odometry_yaw_zero_euler_unit.f
rtl/oyz_pkg.sv
rtl/oyz_ctrl.sv
rtl/oyz_dp.sv
rtl/odometry_yaw_zero_euler_unit.sv
sim/oyz_checker.sv
sim/tb_top.sv
